// ----- rtl/adq_pkg.sv -----
// Package for the array deque engine: sizes, operation and status codes,
// controller state encoding and the controller-to-datapath command struct.
// No dependencies.
package adq_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_BACK  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_BACK   = 3'd3,
    KIND_CLEAR      = 3'd4
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic load;     // capture the request fields
    logic exec;     // carry out the operation on the stored state
  } cmd_t;

endpackage

// ----- rtl/adq_ctrl.sv -----
// Controller of the array deque engine: a one-hot state machine that walks
// each request through capture, execution and result. Depends on adq_pkg.
module adq_ctrl (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        result_valid_o,
  output adq_pkg::cmd_t cmd_o
);
  import adq_pkg::*;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);
  assign cmd_o.load     = (state_q == ST_IDLE) && start_i;
  assign cmd_o.exec     = (state_q == ST_EXEC);

endmodule

// ----- rtl/adq_dp.sv -----
// Datapath of the array deque engine: slot memory, head and tail indices,
// empty flag and result registers. Depends on adq_pkg.
module adq_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  adq_pkg::cmd_t               cmd_i,
  input  logic [adq_pkg::KIND_W-1:0]  kind_i,
  input  logic signed [adq_pkg::DATA_W-1:0] value_i,
  output logic [adq_pkg::STAT_W-1:0]  status_o,
  output logic signed [adq_pkg::DATA_W-1:0] popped_o
);
  import adq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [KIND_W-1:0] kind_q;
  logic [DATA_W-1:0] value_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic              empty_q, empty_d;
  status_e           status_q, status_d;
  logic              pop_ok_q, pop_ok_d;
  logic [DATA_W-1:0] rd_q;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_en;

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    empty_d  = empty_q;
    status_d = STAT_OK;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = '0;
    rd_idx   = tail_q;
    case (kind_e'(kind_q))
      KIND_PUSH_FRONT: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          wr_en   = 1'b1;
        end else if (head_q != '0) begin
          head_d = head_q - IDX_W'(1);
          wr_idx = head_q - IDX_W'(1);
          wr_en  = 1'b1;
        end else begin
          status_d = STAT_OVERFLOW;
        end
      end
      KIND_PUSH_BACK: begin
        if (empty_q) begin
          head_d  = '0;
          tail_d  = '0;
          empty_d = 1'b0;
          wr_en   = 1'b1;
        end else if (tail_q != IDX_W'(DEPTH - 1)) begin
          tail_d = tail_q + IDX_W'(1);
          wr_idx = tail_q + IDX_W'(1);
          wr_en  = 1'b1;
        end else begin
          status_d = STAT_OVERFLOW;
        end
      end
      KIND_POP_FRONT: begin
        rd_idx = head_q;
        if (empty_q) begin
          status_d = STAT_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            head_d = head_q + IDX_W'(1);
          end
        end
      end
      KIND_POP_BACK: begin
        if (empty_q) begin
          status_d = STAT_EMPTY;
        end else begin
          pop_ok_d = 1'b1;
          if (head_q == tail_q) begin
            head_d  = '0;
            tail_d  = '0;
            empty_d = 1'b1;
          end else begin
            tail_d = tail_q - IDX_W'(1);
          end
        end
      end
      KIND_CLEAR: begin
        head_d  = '0;
        tail_d  = '0;
        empty_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Request capture; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
  end

  // Slot memory: at most one write and one registered read per execution cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (wr_en) begin
        mem[wr_idx] <= value_q;
      end
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      tail_q   <= '0;
      empty_q  <= 1'b1;
      status_q <= STAT_OK;
      pop_ok_q <= 1'b0;
    end else if (cmd_i.exec) begin
      head_q   <= head_d;
      tail_q   <= tail_d;
      empty_q  <= empty_d;
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  assign status_o = status_q;
  assign popped_o = pop_ok_q ? rd_q : '0;

endmodule

// ----- rtl/array_deque_engine_core.sv -----
// Top level of the array deque engine: joins the controller and datapath.
// Depends on adq_pkg, adq_ctrl and adq_dp.
//
// Usage. The block holds a double-ended queue of DEPTH 32-bit elements in a
// fixed array whose head and tail indices never wrap round. A request is
// presented on kind_i and value_i together with start_i, and it is accepted
// at the rising edge at which start_i is high and busy_o is low. kind_i
// selects push front, push back, pop front, pop back or clear; other codes
// leave the queue untouched and report success.
// Every request yields exactly one result. It appears on status_o and
// popped_o, marked by result_valid_o for a single cycle, once the
// request has passed through execution. The receiver cannot hold results
// off, so nothing stalls on the result side.
// Each request passes through an execution state, in which the slot memory
// is written through its write port and read through its read port and the
// read data registered, and then a result state; busy_o stays high from
// acceptance until the result cycle has ended, so a new request is taken
// only once the last one is through.
// Reset (rst_ni low, asynchronous) empties the queue and returns the
// controller to idle; slot contents are not cleared, but a slot that has
// not been written is never returned on popped_o.
module array_deque_engine_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [adq_pkg::KIND_W-1:0]         kind_i,
  input  logic signed [adq_pkg::DATA_W-1:0]  value_i,
  output logic                               result_valid_o,
  output logic [adq_pkg::STAT_W-1:0]         status_o,
  output logic signed [adq_pkg::DATA_W-1:0]  popped_o
);
  import adq_pkg::*;

  cmd_t cmd;

  // The controller sequences each request; it needs no status back from
  // the datapath because every operation takes the same number of cycles.
  adq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  // The datapath owns the queue state and forms the result fields.
  adq_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .kind_i   (kind_i),
    .value_i  (value_i),
    .status_o (status_o),
    .popped_o (popped_o)
  );

endmodule

// ----- rtl/adq_checker.sv -----
// Port-level checker for the array deque engine, bound to the top level.
// Depends on adq_pkg and array_deque_engine_core.
module adq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start_i,
  input logic                              busy_o,
  input logic                              result_valid_o,
  input logic [adq_pkg::STAT_W-1:0]        status_o,
  input logic signed [adq_pkg::DATA_W-1:0] popped_o
);
  import adq_pkg::*;

  // An accepted request gives its result once it has passed through execution.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 result_valid_o)
    else $error("result did not follow an accepted request");

  // A result is only shown while the block is busy with its request.
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe outside a busy period");

  // One result per request: the strobe never stays high.
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe repeated");

  // Failed operations return no element.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o != STAT_OK) |-> (popped_o == '0))
    else $error("failed request returned an element");

endmodule

bind array_deque_engine_core adq_checker u_adq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .popped_o       (popped_o)
);
